// ===== rtl/spsbs_pkg.sv =====
package spsbs_pkg;

    localparam int MaxNodes = 64;
    localparam int MaxEdges = 256;
    localparam int WeightBits = 16;
    localparam int NodeBits = 6;
    localparam int EdgeBits = 8;
    localparam int CountBits = 9;
    localparam int DistBits = 30;
    localparam int SumBits = 36;
    localparam int CfgBits = 7;

    localparam logic [DistBits-1:0] InfDist = 30'h3fffffff;
    localparam logic [SumBits-1:0] SumLimit = 36'hfffffffff;

    localparam logic OpAddEdge = 1'b0;
    localparam logic OpEvaluate = 1'b1;

    typedef struct packed {
        logic [NodeBits-1:0] a;
        logic [NodeBits-1:0] b;
        logic [WeightBits-1:0] w;
    } edge_t;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_CLEAR,
        ST_POP,
        ST_POP_WAIT,
        ST_EDGE_RD,
        ST_EDGE_CHK,
        ST_DIST_WAIT,
        ST_RELAX,
        ST_SUM_RD,
        ST_SUM_ADD,
        ST_FINISH
    } state_t;

endpackage

// ===== rtl/spsbs_dist_mem.sv =====
module spsbs_dist_mem (
    input  logic                                clk,
    input  logic                                we,
    input  logic [spsbs_pkg::NodeBits-1:0]      waddr,
    input  logic [spsbs_pkg::DistBits-1:0]      wdata,
    input  logic [spsbs_pkg::NodeBits-1:0]      raddr,
    output logic [spsbs_pkg::DistBits-1:0]      rdata
);

    logic [spsbs_pkg::DistBits-1:0] mem [spsbs_pkg::MaxNodes];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule

// ===== rtl/spsbs_edge_mem.sv =====
module spsbs_edge_mem (
    input  logic                                clk,
    input  logic                                we,
    input  logic [spsbs_pkg::EdgeBits-1:0]      waddr,
    input  spsbs_pkg::edge_t                    wdata,
    input  logic [spsbs_pkg::EdgeBits-1:0]      raddr,
    output spsbs_pkg::edge_t                    rdata
);

    spsbs_pkg::edge_t mem [spsbs_pkg::MaxEdges];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule

// ===== rtl/spsbs_queue_mem.sv =====
module spsbs_queue_mem (
    input  logic                                clk,
    input  logic                                we,
    input  logic [spsbs_pkg::NodeBits-1:0]      waddr,
    input  logic [spsbs_pkg::NodeBits-1:0]      wdata,
    input  logic [spsbs_pkg::NodeBits-1:0]      raddr,
    output logic [spsbs_pkg::NodeBits-1:0]      rdata
);

    logic [spsbs_pkg::NodeBits-1:0] mem [spsbs_pkg::MaxNodes];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule

// ===== rtl/shortest_path_sum_best_source.sv =====
// edge add and rejected evaluate: result strobed on done the cycle after start
// evaluate: clears all 64 distance entries, then per dequeued node reads every stored edge
// and relaxes each incident edge end, then a final pop and a sum over the n distances
// busy is high throughout an evaluate; one item at a time; the receiver cannot stall
// reset: no edges, node_count 64, no best source; edge store holds no reset
module shortest_path_sum_best_source (
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                start,
    output logic                                busy,
    input  logic                                cfg_we,
    input  logic [spsbs_pkg::CfgBits-1:0]       cfg_wdata,
    input  logic                                operation,
    input  logic [spsbs_pkg::NodeBits-1:0]      node_a,
    input  logic [spsbs_pkg::NodeBits-1:0]      node_b,
    input  logic [spsbs_pkg::WeightBits-1:0]    weight,
    output logic                                done,
    output logic                                accepted,
    output logic [spsbs_pkg::SumBits-1:0]       distance_sum,
    output logic                                best_found,
    output logic [spsbs_pkg::NodeBits-1:0]      best_source,
    output logic [spsbs_pkg::DistBits-1:0]      best_sum
);

    localparam int NB = spsbs_pkg::NodeBits;
    localparam int DB = spsbs_pkg::DistBits;

    spsbs_pkg::state_t state_reg, state_next;

    logic [spsbs_pkg::CfgBits-1:0] node_count_reg;
    logic [spsbs_pkg::CountBits-1:0] edge_count_reg;
    logic [DB-1:0] best_sum_reg;
    logic [NB-1:0] best_source_reg;
    logic [NB-1:0] src_reg;
    logic [NB:0] n_reg;
    logic [NB:0] idx_reg;
    logic [spsbs_pkg::CountBits-1:0] eidx_reg;
    logic [NB-1:0] head_reg;
    logic [NB:0] qsize_reg;
    logic [spsbs_pkg::MaxNodes-1:0] inq_reg;
    logic [NB-1:0] u_reg;
    logic [DB-1:0] du_reg;
    logic [NB-1:0] v_reg;
    logic [NB-1:0] v2_reg;
    logic second_reg;
    logic has2_reg;
    logic [spsbs_pkg::WeightBits-1:0] w_reg;
    logic [DB-1:0] cand_reg;
    logic [spsbs_pkg::SumBits:0] sum_reg;

    logic [NB:0] n_eff;
    logic item_go;

    // memory ports
    logic dist_we;
    logic [NB-1:0] dist_waddr, dist_raddr;
    logic [DB-1:0] dist_wdata, dist_rdata;
    logic edge_we;
    spsbs_pkg::edge_t edge_wdata, edge_rdata;
    logic q_we;
    logic [NB-1:0] q_waddr, q_wdata, q_rdata;

    spsbs_dist_mem u_dist (
        .clk   (clk),
        .we    (dist_we),
        .waddr (dist_waddr),
        .wdata (dist_wdata),
        .raddr (dist_raddr),
        .rdata (dist_rdata)
    );

    spsbs_edge_mem u_edge (
        .clk   (clk),
        .we    (edge_we),
        .waddr (edge_count_reg[spsbs_pkg::EdgeBits-1:0]),
        .wdata (edge_wdata),
        .raddr (eidx_reg[spsbs_pkg::EdgeBits-1:0]),
        .rdata (edge_rdata)
    );

    spsbs_queue_mem u_queue (
        .clk   (clk),
        .we    (q_we),
        .waddr (q_waddr),
        .wdata (q_wdata),
        .raddr (head_reg),
        .rdata (q_rdata)
    );

    always_comb
    begin
        if (node_count_reg == '0)
        begin
            n_eff = (NB+1)'(1);
        end
        else if (node_count_reg > spsbs_pkg::CfgBits'(spsbs_pkg::MaxNodes))
        begin
            n_eff = (NB+1)'(spsbs_pkg::MaxNodes);
        end
        else
        begin
            n_eff = (NB+1)'(node_count_reg);
        end
    end

    assign item_go = start && !busy;
    assign busy = (state_reg != spsbs_pkg::ST_IDLE);

    // edge check and relax candidate
    logic edge_ok;
    logic [NB-1:0] ea, eb;
    logic [DB:0] cand_sum;
    logic improve;
    logic [NB-1:0] relax_v;
    logic push_ok;

    assign ea = edge_rdata.a;
    assign eb = edge_rdata.b;
    assign edge_ok = ((NB+1)'(ea) < n_reg) && ((NB+1)'(eb) < n_reg);
    assign cand_sum = (DB+1)'(du_reg) + (DB+1)'(w_reg);
    assign relax_v = second_reg ? v2_reg : v_reg;
    assign improve = cand_reg < dist_rdata;
    assign push_ok = !inq_reg[relax_v] && (qsize_reg < (NB+1)'(spsbs_pkg::MaxNodes));

    // next state
    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            spsbs_pkg::ST_IDLE:
            begin
                if (item_go && operation == spsbs_pkg::OpEvaluate
                    && (NB+1)'(node_a) < n_eff)
                begin
                    state_next = spsbs_pkg::ST_CLEAR;
                end
            end
            spsbs_pkg::ST_CLEAR:
            begin
                if (idx_reg == (NB+1)'(spsbs_pkg::MaxNodes - 1))
                begin
                    state_next = spsbs_pkg::ST_POP;
                end
            end
            spsbs_pkg::ST_POP:
            begin
                if (qsize_reg == '0)
                begin
                    state_next = spsbs_pkg::ST_SUM_RD;
                end
                else
                begin
                    state_next = spsbs_pkg::ST_POP_WAIT;
                end
            end
            spsbs_pkg::ST_POP_WAIT:
            begin
                state_next = spsbs_pkg::ST_EDGE_RD;
            end
            spsbs_pkg::ST_EDGE_RD:
            begin
                if (eidx_reg >= edge_count_reg)
                begin
                    state_next = spsbs_pkg::ST_POP;
                end
                else
                begin
                    state_next = spsbs_pkg::ST_EDGE_CHK;
                end
            end
            spsbs_pkg::ST_EDGE_CHK:
            begin
                if (edge_ok && (ea == u_reg || eb == u_reg))
                begin
                    state_next = spsbs_pkg::ST_DIST_WAIT;
                end
                else
                begin
                    state_next = spsbs_pkg::ST_EDGE_RD;
                end
            end
            spsbs_pkg::ST_DIST_WAIT:
            begin
                state_next = spsbs_pkg::ST_RELAX;
            end
            spsbs_pkg::ST_RELAX:
            begin
                if (!second_reg && has2_reg)
                begin
                    state_next = spsbs_pkg::ST_DIST_WAIT;
                end
                else
                begin
                    state_next = spsbs_pkg::ST_EDGE_RD;
                end
            end
            spsbs_pkg::ST_SUM_RD:
            begin
                state_next = spsbs_pkg::ST_SUM_ADD;
            end
            spsbs_pkg::ST_SUM_ADD:
            begin
                if (idx_reg == n_reg)
                begin
                    state_next = spsbs_pkg::ST_FINISH;
                end
                else
                begin
                    state_next = spsbs_pkg::ST_SUM_ADD;
                end
            end
            spsbs_pkg::ST_FINISH:
            begin
                state_next = spsbs_pkg::ST_IDLE;
            end
            default:
            begin
                state_next = spsbs_pkg::ST_IDLE;
            end
        endcase
    end

    // memory control
    always_comb
    begin
        dist_we = 1'b0;
        dist_waddr = relax_v;
        dist_wdata = cand_reg;
        dist_raddr = relax_v;
        edge_we = 1'b0;
        edge_wdata.a = node_a;
        edge_wdata.b = node_b;
        edge_wdata.w = weight;
        q_we = 1'b0;
        q_waddr = head_reg + qsize_reg[NB-1:0];
        q_wdata = relax_v;
        unique case (state_reg) inside
            spsbs_pkg::ST_IDLE:
            begin
                edge_we = item_go && operation == spsbs_pkg::OpAddEdge
                    && (NB+1)'(node_a) < n_eff && (NB+1)'(node_b) < n_eff
                    && edge_count_reg < spsbs_pkg::CountBits'(spsbs_pkg::MaxEdges);
                q_we = 1'b1;
                q_waddr = '0;
                q_wdata = node_a;
            end
            spsbs_pkg::ST_CLEAR:
            begin
                dist_we = 1'b1;
                dist_waddr = idx_reg[NB-1:0];
                dist_wdata = (idx_reg[NB-1:0] == src_reg) ? '0 : spsbs_pkg::InfDist;
            end
            spsbs_pkg::ST_POP_WAIT:
            begin
                dist_raddr = q_rdata;
            end
            spsbs_pkg::ST_RELAX:
            begin
                dist_we = improve;
                q_we = improve && push_ok;
            end
            spsbs_pkg::ST_SUM_RD, spsbs_pkg::ST_SUM_ADD:
            begin
                dist_raddr = idx_reg[NB-1:0];
            end
            default:
            begin
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= spsbs_pkg::ST_IDLE;
            node_count_reg <= spsbs_pkg::CfgBits'(spsbs_pkg::MaxNodes);
            edge_count_reg <= '0;
            best_sum_reg <= spsbs_pkg::InfDist;
            best_source_reg <= '0;
            done <= 1'b0;
            accepted <= 1'b0;
            distance_sum <= '0;
            inq_reg <= '0;
            qsize_reg <= '0;
        end
        else
        begin
            state_reg <= state_next;
            done <= 1'b0;
            if (cfg_we)
            begin
                node_count_reg <= cfg_wdata;
            end
            unique case (state_reg)
                spsbs_pkg::ST_IDLE:
                begin
                    if (item_go)
                    begin
                        src_reg <= node_a;
                        n_reg <= n_eff;
                        idx_reg <= '0;
                        if (operation == spsbs_pkg::OpAddEdge)
                        begin
                            done <= 1'b1;
                            accepted <= edge_we;
                            distance_sum <= '0;
                            if (edge_we)
                            begin
                                edge_count_reg <= edge_count_reg + 1'b1;
                            end
                        end
                        else if ((NB+1)'(node_a) >= n_eff)
                        begin
                            done <= 1'b1;
                            accepted <= 1'b0;
                            distance_sum <= '0;
                        end
                        else
                        begin
                            head_reg <= '0;
                            qsize_reg <= (NB+1)'(1);
                            // flags are all clear here, every pushed node was popped
                            inq_reg[node_a] <= 1'b1;
                        end
                    end
                end
                spsbs_pkg::ST_CLEAR:
                begin
                    idx_reg <= idx_reg + 1'b1;
                end
                spsbs_pkg::ST_POP:
                begin
                    idx_reg <= '0;
                    sum_reg <= '0;
                end
                spsbs_pkg::ST_POP_WAIT:
                begin
                    u_reg <= q_rdata;
                    inq_reg[q_rdata] <= 1'b0;
                    head_reg <= head_reg + 1'b1;
                    qsize_reg <= qsize_reg - 1'b1;
                    eidx_reg <= '0;
                end
                spsbs_pkg::ST_EDGE_RD:
                begin
                    if (eidx_reg == '0)
                    begin
                        du_reg <= dist_rdata;
                    end
                end
                spsbs_pkg::ST_EDGE_CHK:
                begin
                    eidx_reg <= eidx_reg + 1'b1;
                    w_reg <= edge_rdata.w;
                    second_reg <= 1'b0;
                    // a==u relaxes b first, then b==u relaxes a
                    if (ea == u_reg)
                    begin
                        v_reg <= eb;
                        v2_reg <= ea;
                        has2_reg <= (eb == u_reg);
                    end
                    else
                    begin
                        v_reg <= ea;
                        has2_reg <= 1'b0;
                    end
                end
                spsbs_pkg::ST_DIST_WAIT:
                begin
                    cand_reg <= (cand_sum > (DB+1)'(spsbs_pkg::InfDist - 1'b1))
                        ? spsbs_pkg::InfDist - 1'b1 : cand_sum[DB-1:0];
                end
                spsbs_pkg::ST_RELAX:
                begin
                    second_reg <= 1'b1;
                    if (improve && push_ok)
                    begin
                        inq_reg[relax_v] <= 1'b1;
                        qsize_reg <= qsize_reg + 1'b1;
                    end
                end
                spsbs_pkg::ST_SUM_RD:
                begin
                    idx_reg <= idx_reg + 1'b1;
                end
                spsbs_pkg::ST_SUM_ADD:
                begin
                    sum_reg <= sum_reg + (spsbs_pkg::SumBits+1)'(dist_rdata);
                    idx_reg <= idx_reg + 1'b1;
                end
                spsbs_pkg::ST_FINISH:
                begin
                    done <= 1'b1;
                    accepted <= 1'b1;
                    if (sum_reg > (spsbs_pkg::SumBits+1)'(spsbs_pkg::SumLimit))
                    begin
                        distance_sum <= spsbs_pkg::SumLimit;
                    end
                    else
                    begin
                        distance_sum <= sum_reg[spsbs_pkg::SumBits-1:0];
                    end
                    if (sum_reg < (spsbs_pkg::SumBits+1)'(best_sum_reg))
                    begin
                        best_sum_reg <= sum_reg[DB-1:0];
                        best_source_reg <= src_reg;
                    end
                end
                default:
                begin
                end
            endcase
        end
    end

    always_comb
    begin
        best_found = best_sum_reg < spsbs_pkg::InfDist;
        best_source = best_found ? best_source_reg : '0;
        best_sum = best_found ? best_sum_reg : '0;
    end

endmodule
